// ----- rtl/yqrgb_pkg.sv -----
// yqrgb_pkg: shared types, constants and helpers for the 4:2:0 quad to rgb pipeline
// used by every module in rtl; depends on nothing
package yqrgb_pkg;

	localparam int LUMA_W   = 8;
	localparam int PROD_W   = 16;
	localparam int SUM_W    = 11;
	localparam int IN_W     = 48;
	localparam int PIXEL_W  = 32;
	localparam int OUT_W    = 128;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_SWAP_RED_BLUE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE_PIXELS = 2'd1;

	localparam logic signed [PROD_W-1:0] COEF_RED_FROM_CR   = 16'sd163;
	localparam logic signed [PROD_W-1:0] COEF_GREEN_FROM_CB = 16'sd54;
	localparam logic signed [PROD_W-1:0] COEF_GREEN_FROM_CR = 16'sd97;
	localparam logic signed [PROD_W-1:0] COEF_BLUE_FROM_CB  = 16'sd136;
	localparam logic [LUMA_W:0]          CHROMA_OFFSET      = 9'd128;
	localparam logic [LUMA_W-1:0]        ALPHA_OPAQUE       = 8'hFF;

	typedef logic [LUMA_W-1:0] luma_t;
	typedef logic signed [SUM_W-1:0] sum_val_t;

	// stage 1 result: chroma products and the luma that rides along
	typedef struct packed {
		luma_t [3:0]              luma;
		logic signed [PROD_W-1:0] prod_r;
		logic signed [PROD_W-1:0] prod_g;
		logic signed [PROD_W-1:0] prod_b;
	} prod_beat_t;

	// stage 2 result: unclamped luma plus term per pixel and color
	typedef struct packed {
		sum_val_t [3:0] red;
		sum_val_t [3:0] green;
		sum_val_t [3:0] blue;
	} sum_beat_t;

	typedef struct packed {
		logic swap_red_blue;
		logic four_byte_pixels;
	} cfg_t;

	function automatic luma_t clamp8(input sum_val_t v);
		luma_t r;
		if (v[SUM_W-1])
			r = '0;
		else if (|v[SUM_W-2:LUMA_W])
			r = '1;
		else
			r = v[LUMA_W-1:0];
		return r;
	endfunction

endpackage

// ----- rtl/yqrgb_chroma.sv -----
// yqrgb_chroma: stage 1, removes the chroma offset and forms the three products
// depends on yqrgb_pkg
module yqrgb_chroma (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [yqrgb_pkg::IN_W-1:0] in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output yqrgb_pkg::prod_beat_t      out_beat
);

	logic                                  valid_s1;
	yqrgb_pkg::prod_beat_t                 beat_s1;
	logic signed [yqrgb_pkg::LUMA_W:0]     cb;
	logic signed [yqrgb_pkg::LUMA_W:0]     cr;
	logic signed [yqrgb_pkg::PROD_W-1:0]   cb_ext;
	logic signed [yqrgb_pkg::PROD_W-1:0]   cr_ext;
	yqrgb_pkg::prod_beat_t                 beat_d;

	assign cb = $signed({1'b0, in_data[39:32]} - yqrgb_pkg::CHROMA_OFFSET);
	assign cr = $signed({1'b0, in_data[47:40]} - yqrgb_pkg::CHROMA_OFFSET);
	assign cb_ext = yqrgb_pkg::PROD_W'(cb);
	assign cr_ext = yqrgb_pkg::PROD_W'(cr);

	always_comb begin
		beat_d.luma[0] = in_data[7:0];
		beat_d.luma[1] = in_data[15:8];
		beat_d.luma[2] = in_data[23:16];
		beat_d.luma[3] = in_data[31:24];
		beat_d.prod_r  = cr_ext * yqrgb_pkg::COEF_RED_FROM_CR;
		beat_d.prod_g  = -(cb_ext * yqrgb_pkg::COEF_GREEN_FROM_CB)
			- cr_ext * yqrgb_pkg::COEF_GREEN_FROM_CR;
		beat_d.prod_b  = cb_ext * yqrgb_pkg::COEF_BLUE_FROM_CB;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= beat_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_beat  = beat_s1;

endmodule

// ----- rtl/yqrgb_sum.sv -----
// yqrgb_sum: stage 2, shifts the products into chroma terms and adds them to each luma
// depends on yqrgb_pkg
module yqrgb_sum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  yqrgb_pkg::prod_beat_t in_beat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output yqrgb_pkg::sum_beat_t  out_beat
);

	logic                   valid_s2;
	yqrgb_pkg::sum_beat_t   beat_s2;
	yqrgb_pkg::sum_beat_t   beat_d;
	yqrgb_pkg::sum_val_t    term_r;
	yqrgb_pkg::sum_val_t    term_g;
	yqrgb_pkg::sum_val_t    term_b;
	yqrgb_pkg::sum_val_t    luma_ext [4];

	// arithmetic shifts round toward minus infinity
	assign term_r = yqrgb_pkg::SUM_W'(in_beat.prod_r >>> 7);
	assign term_g = yqrgb_pkg::SUM_W'(in_beat.prod_g >>> 8);
	assign term_b = yqrgb_pkg::SUM_W'(in_beat.prod_b >>> 6);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			luma_ext[i]       = $signed({3'b000, in_beat.luma[i]});
			beat_d.red[i]     = luma_ext[i] + term_r;
			beat_d.green[i]   = luma_ext[i] + term_g;
			beat_d.blue[i]    = luma_ext[i] + term_b;
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s2 <= beat_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_beat  = beat_s2;

endmodule

// ----- rtl/yqrgb_pack.sv -----
// yqrgb_pack: stage 3, clamps each sum to a byte and packs the four pixels
// depends on yqrgb_pkg
module yqrgb_pack (
	input  logic                        clk,
	input  logic                        arst_n,
	input  yqrgb_pkg::cfg_t             cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  yqrgb_pkg::sum_beat_t        in_beat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [yqrgb_pkg::OUT_W-1:0] out_data
);

	logic                                 valid_s3;
	logic [yqrgb_pkg::OUT_W-1:0]          data_s3;
	logic [yqrgb_pkg::OUT_W-1:0]          data_d;
	yqrgb_pkg::luma_t                     red;
	yqrgb_pkg::luma_t                     green;
	yqrgb_pkg::luma_t                     blue;
	yqrgb_pkg::luma_t                     alpha;

	assign alpha = cfg.four_byte_pixels ? yqrgb_pkg::ALPHA_OPAQUE : '0;

	always_comb begin
		data_d = '0;
		red    = '0;
		green  = '0;
		blue   = '0;
		for (int i = 0; i < 4; i++) begin
			red   = yqrgb_pkg::clamp8(in_beat.red[i]);
			green = yqrgb_pkg::clamp8(in_beat.green[i]);
			blue  = yqrgb_pkg::clamp8(in_beat.blue[i]);
			data_d[i*yqrgb_pkg::PIXEL_W +: yqrgb_pkg::PIXEL_W] = cfg.swap_red_blue
				? {alpha, red, green, blue}
				: {alpha, blue, green, red};
		end
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3 <= data_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

// ----- rtl/yuv420_quad_to_rgb_top.sv -----
// yuv420_quad_to_rgb_top: 4:2:0 quad to packed rgb converter, top level
// depends on yqrgb_pkg, yqrgb_chroma, yqrgb_sum, yqrgb_pack
//
// usage:
//   s_axis carries one 2x2 quad per beat: four luma bytes and the shared
//   blue and red chroma bytes. m_axis carries four packed 32-bit pixels per
//   beat, byte 0 red (blue when swapped), byte 1 green, byte 2 the other
//   color, byte 3 alpha 0xff in four-byte mode and zero otherwise.
//   cfg_we/cfg_index/cfg_data write swap_red_blue (index 0) and
//   four_byte_pixels (index 1); write only while no beat is in flight.
//   an accepted input beat passes through three register stages: products,
//   chroma terms plus luma, clamp and pack. throughput is one quad per
//   cycle while m_axis_tready stays high; every stage takes a new beat
//   whenever it is empty or its successor takes its beat.
//   reset empties all three stages and loads swap_red_blue = 0 and
//   four_byte_pixels = 1.
//   when m_axis_tready is low the output beat holds, stages behind it keep
//   filling empty slots, and s_axis_tready drops once all three are full.
module yuv420_quad_to_rgb_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
	// chroma_blue, chroma_red
	input  logic [yqrgb_pkg::IN_W-1:0]        s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right
	output logic [yqrgb_pkg::OUT_W-1:0]       m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [yqrgb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [yqrgb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	yqrgb_pkg::cfg_t        cfg_q;
	logic                   v1;
	logic                   rdy2;
	logic                   v2;
	logic                   rdy3;
	yqrgb_pkg::prod_beat_t  prod_beat;
	yqrgb_pkg::sum_beat_t   sum_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.swap_red_blue    <= 1'b0;
			cfg_q.four_byte_pixels <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				yqrgb_pkg::CFG_SWAP_RED_BLUE:    cfg_q.swap_red_blue    <= cfg_data[0];
				yqrgb_pkg::CFG_FOUR_BYTE_PIXELS: cfg_q.four_byte_pixels <= cfg_data[0];
				default: ;
			endcase
		end
	end

	yqrgb_chroma u_chroma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (v1),
		.out_ready (rdy2),
		.out_beat  (prod_beat)
	);

	yqrgb_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (rdy2),
		.in_beat   (prod_beat),
		.out_valid (v2),
		.out_ready (rdy3),
		.out_beat  (sum_beat)
	);

	yqrgb_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (v2),
		.in_ready  (rdy3),
		.in_beat   (sum_beat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	// a stalled stage keeps its beat
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v1 && !rdy2 |=> v1)
		else $error("stage 1 beat lost under stall");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v2 && !rdy3 |=> v2)
		else $error("stage 2 beat lost under stall");

	// full pipe with stalled output takes no input
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		v1 && v2 && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted into a full pipeline");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:24] == 8'h00 || m_axis_tdata[31:24] == 8'hFF))
		else $error("alpha byte neither zero nor opaque");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for yuv420_quad_to_rgb_top, one 2x2 quad in and four pixels out
// depends on yqrgb_pkg and the rtl; the scoreboard class predicts each quad from its own config copy
module tb_top;

	localparam logic [yqrgb_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [yqrgb_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
	localparam int STUCK_LIMIT = 2000;
	localparam int PIPE_DEPTH  = 3;
	localparam int IDLE_PCT    = 21;
	localparam int HOLD_CYCLES = 60;

	typedef struct packed {
		logic [7:0]             chroma_red;
		logic [7:0]             chroma_blue;
		yqrgb_pkg::luma_t [3:0] luma;        // 0 top left, 1 top right, 2 bottom left, 3 bottom right
	} quad_t;

	typedef logic [3:0][yqrgb_pkg::PIXEL_W-1:0] pixel_quad_t;

	class quad_scoreboard;
		bit swap_rb;
		bit alpha_on;
		pixel_quad_t expected_q[$];
		int errors;

		function new();
			swap_rb  = 1'b0;
			alpha_on = 1'b1;
			errors   = 0;
		endfunction

		function void set_reg(logic [yqrgb_pkg::CFG_IDX_W-1:0] idx,
			logic [yqrgb_pkg::CFG_DATA_W-1:0] val);
			if (idx == yqrgb_pkg::CFG_SWAP_RED_BLUE)
				swap_rb = val[0];
			else if (idx == yqrgb_pkg::CFG_FOUR_BYTE_PIXELS)
				alpha_on = val[0];
		endfunction

		function logic [7:0] sat8(int v);
			if (v < 0)
				return 8'd0;
			if (v > 255)
				return 8'd255;
			return v[7:0];
		endfunction

		function void note_quad(quad_t q);
			int cb, cr, dr, dg, db, y;
			logic [7:0] red, green, blue;
			pixel_quad_t p;
			cb = int'(q.chroma_blue) - int'(yqrgb_pkg::CHROMA_OFFSET);
			cr = int'(q.chroma_red) - int'(yqrgb_pkg::CHROMA_OFFSET);
			dr = (cr * int'(yqrgb_pkg::COEF_RED_FROM_CR)) >>> 7;
			dg = (-(cb * int'(yqrgb_pkg::COEF_GREEN_FROM_CB))
				- cr * int'(yqrgb_pkg::COEF_GREEN_FROM_CR)) >>> 8;
			db = (cb * int'(yqrgb_pkg::COEF_BLUE_FROM_CB)) >>> 6;
			for (int i = 0; i < 4; i++) begin
				y = int'(q.luma[i]);
				red   = sat8(y + dr);
				green = sat8(y + dg);
				blue  = sat8(y + db);
				p[i] = {alpha_on ? yqrgb_pkg::ALPHA_OPAQUE : 8'd0,
					swap_rb ? red : blue, green, swap_rb ? blue : red};
			end
			expected_q.push_back(p);
		endfunction

		function void check_pixels(pixel_quad_t got);
			pixel_quad_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected output beat, actual %h", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			for (int i = 0; i < 4; i++)
				if (got[i] !== want[i]) begin
					$display("%0t: pixel %0d mismatch, expected %h actual %h",
						$time, i, want[i], got[i]);
					errors++;
				end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [yqrgb_pkg::IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [yqrgb_pkg::OUT_W-1:0] m_axis_tdata;
	logic cfg_we;
	logic [yqrgb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [yqrgb_pkg::CFG_DATA_W-1:0] cfg_data;

	logic no_gaps;
	logic long_hold;
	int stuck_cycles;
	quad_scoreboard sb;

	yuv420_quad_to_rgb_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold <= 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_pixels(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(99) < 25) begin
			case ($urandom_range(6))
				0: return 8'd0;
				1: return 8'd1;
				2: return 8'd127;
				3: return 8'd128;
				4: return 8'd129;
				5: return 8'd254;
				default: return 8'd255;
			endcase
		end
		return 8'($urandom);
	endfunction

	function automatic quad_t random_quad();
		quad_t q;
		for (int i = 0; i < 4; i++)
			q.luma[i] = pick_byte();
		q.chroma_blue = pick_byte();
		q.chroma_red  = pick_byte();
		return q;
	endfunction

	function automatic quad_t mk_quad(logic [7:0] tl, logic [7:0] tr, logic [7:0] bl,
		logic [7:0] br, logic [7:0] cb, logic [7:0] cr);
		quad_t q;
		q.luma[0] = tl;
		q.luma[1] = tr;
		q.luma[2] = bl;
		q.luma[3] = br;
		q.chroma_blue = cb;
		q.chroma_red  = cr;
		return q;
	endfunction

	task automatic send_quad(input quad_t q);
		while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= q;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_quad(q);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [yqrgb_pkg::CFG_IDX_W-1:0] idx,
		input logic [yqrgb_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic run_phase(input logic swap, input logic alpha, input int count,
		input logic hold, input logic steady);
		drain();
		write_reg(yqrgb_pkg::CFG_SWAP_RED_BLUE, swap);
		write_reg(yqrgb_pkg::CFG_FOUR_BYTE_PIXELS, alpha);
		no_gaps <= steady;
		if (hold)
			long_hold <= 1'b1;
		repeat (count)
			send_quad(random_quad());
		no_gaps <= 1'b0;
	endtask

	initial begin
		quad_t directed[$];
		sb = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		no_gaps       = 1'b0;
		long_hold     = 1'b0;
		stuck_cycles  = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// writes to unused indexes must leave the reset config alone
		write_reg(CFG_SPARE_2, 1'b1);
		write_reg(CFG_SPARE_3, 1'b1);
		write_reg(CFG_SPARE_3, 1'b0);

		directed.push_back(mk_quad(8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128));
		directed.push_back(mk_quad(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128));
		directed.push_back(mk_quad(8'd0, 8'd85, 8'd170, 8'd255, 8'd0, 8'd0));
		directed.push_back(mk_quad(8'd0, 8'd85, 8'd170, 8'd255, 8'd255, 8'd255));
		directed.push_back(mk_quad(8'd0, 8'd85, 8'd170, 8'd255, 8'd0, 8'd255));
		directed.push_back(mk_quad(8'd0, 8'd85, 8'd170, 8'd255, 8'd255, 8'd0));
		directed.push_back(mk_quad(8'd16, 8'd235, 8'd16, 8'd235, 8'd127, 8'd129));
		directed.push_back(mk_quad(8'd128, 8'd128, 8'd128, 8'd128, 8'd129, 8'd127));
		directed.push_back(mk_quad(8'd1, 8'd254, 8'd2, 8'd253, 8'd1, 8'd254));
		directed.push_back(mk_quad(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255));
		directed.push_back(mk_quad(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0));
		directed.push_back(mk_quad(8'd100, 8'd20, 8'd240, 8'd5, 8'd200, 8'd60));
		directed.push_back(mk_quad(8'd50, 8'd60, 8'd70, 8'd80, 8'd64, 8'd192));
		directed.push_back(mk_quad(8'd170, 8'd85, 8'd240, 8'd15, 8'd126, 8'd130));
		foreach (directed[i])
			send_quad(directed[i]);

		run_phase(1'b0, 1'b0, 260, 1'b0, 1'b0);
		run_phase(1'b1, 1'b0, 260, 1'b1, 1'b0);
		run_phase(1'b1, 1'b1, 260, 1'b0, 1'b1);
		run_phase(1'b0, 1'b1, 260, 1'b1, 1'b0);
		run_phase(1'b1, 1'b0, 260, 1'b0, 1'b0);

		drain();
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/yqrgb_pkg.sv
rtl/yqrgb_chroma.sv
rtl/yqrgb_sum.sv
rtl/yqrgb_pack.sv
rtl/yuv420_quad_to_rgb_top.sv
sim/tb_top.sv
